// ===== hdl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring FIFO: field widths, request
// kind codes, command queue entry and result beat layouts.
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int KIND_W  = 2;
   localparam int LEN_W   = 7;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 10;
   localparam int CNT_MAX = 1023;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = 2;

   typedef enum logic [2:0] {
      CMD_RESULT,
      CMD_WRITE,
      CMD_CLEAR,
      CMD_READ,
      CMD_PEEK
   } cmd_op_type;

   // len holds the byte count of a read or peek, else the moved count
   typedef struct packed {
      cmd_op_type        op;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              status;
      logic              last;
      logic [CNT_W-1:0]  held_cnt;
      logic [CNT_W-1:0]  free_cnt;
   } cmd_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [LEN_W-1:0]  moved;
      logic [CNT_W-1:0]  held_cnt;
      logic [CNT_W-1:0]  free_cnt;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== hdl/brf_front.sv =====
// ----------------------------------------------------------------------------
// brf_front
// Request front end: holds capacity, ring pointers and write transfer state,
// classifies each request and queues one command per result source.
// ----------------------------------------------------------------------------
module brf_front #(
   parameter int DEPTH    = 1024,
   parameter int MAX_XFER = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [brf_pkg::KIND_W-1:0]     req_kind,
   input  logic                           req_first,
   input  logic [brf_pkg::LEN_W-1:0]      req_length,
   input  logic [brf_pkg::BYTE_W-1:0]     req_data_in,
   input  logic                           csr_wr,
   input  logic [brf_pkg::CNT_W-1:0]      csr_data,
   input  brf_pkg::q_status_type          q_status,
   output logic                           cmd_push,
   output brf_pkg::cmd_type               cmd,
   output logic [brf_pkg::CNT_W-1:0]      usable
);
   import brf_pkg::*;

   localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HW  = ((PW > CNT_W) ? PW : CNT_W) + 1;
   localparam int LIM = (DEPTH - 1 > CNT_MAX) ? CNT_MAX : DEPTH - 1;

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [PW-1:0]    wp_ff, wp_in;
   logic [PW-1:0]    rp_ff, rp_in;
   logic [LEN_W-1:0] wleft_ff, wleft_in;
   logic [LEN_W-1:0] wlen_ff, wlen_in;
   logic             wdrop_ff, wdrop_in;

   logic [HW-1:0]    slots_x, held_x, rsum_x;
   logic [CNT_W-1:0] held_cnt, free_cnt;
   logic             accept, bad_write, bad_read, store;
   logic [LEN_W-1:0] left_eff, len_eff;

   function automatic logic [PW-1:0] adv1(input logic [PW-1:0] p,
                                          input logic [CNT_W-1:0] u);
      return (HW'(p) >= HW'(u)) ? '0 : p + 1'b1;
   endfunction

   assign usable   = (cap_ff > CNT_W'(LIM)) ? CNT_W'(LIM) : cap_ff;
   assign slots_x  = HW'(usable) + HW'(1);
   assign held_x   = (HW'(wp_ff) >= HW'(rp_ff)) ? HW'(wp_ff) - HW'(rp_ff)
                                                : HW'(wp_ff) + slots_x - HW'(rp_ff);
   assign held_cnt = CNT_W'(held_x);
   assign free_cnt = usable - held_cnt;
   assign accept   = req_push & ~q_status.full;

   assign bad_write = (req_length == '0) || (req_length > LEN_W'(MAX_XFER))
                      || (CNT_W'(req_length) > free_cnt);
   assign bad_read  = (req_length > LEN_W'(MAX_XFER))
                      || (CNT_W'(req_length) > held_cnt);

   assign rsum_x = HW'(rp_ff) + HW'(req_length);

   always_comb begin
      cap_in    = cap_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      wleft_in  = wleft_ff;
      wlen_in   = wlen_ff;
      wdrop_in  = wdrop_ff;
      store     = 1'b0;
      left_eff  = wleft_ff;
      len_eff   = wlen_ff;
      cmd_push  = 1'b0;
      cmd.op       = CMD_RESULT;
      cmd.data     = req_data_in;
      cmd.len      = '0;
      cmd.status   = 1'b0;
      cmd.last     = 1'b1;
      cmd.held_cnt = held_cnt;
      cmd.free_cnt = free_cnt;
      if (csr_wr) begin
         cap_in   = csr_data;
         wp_in    = '0;
         rp_in    = '0;
         wleft_in = '0;
         wlen_in  = '0;
         wdrop_in = 1'b0;
      end else if (accept) begin
         unique case (req_kind)
            KIND_WRITE: begin
               if (req_first) begin
                  if (bad_write) begin
                     wdrop_in   = 1'b1;
                     wleft_in   = '0;
                     wlen_in    = '0;
                     cmd_push   = 1'b1;
                     cmd.status = 1'b1;
                  end else begin
                     wdrop_in = 1'b0;
                     left_eff = req_length;
                     len_eff  = req_length;
                     store    = 1'b1;
                  end
               end else if (!wdrop_ff && wleft_ff != '0) begin
                  store = 1'b1;
               end
               if (store) begin
                  wp_in        = adv1(wp_ff, usable);
                  wleft_in     = left_eff - 1'b1;
                  cmd_push     = 1'b1;
                  cmd.op       = CMD_WRITE;
                  cmd.held_cnt = held_cnt + 1'b1;
                  cmd.free_cnt = free_cnt - 1'b1;
                  if (left_eff == LEN_W'(1)) begin
                     cmd.last = 1'b1;
                     cmd.len  = len_eff;
                     wlen_in  = '0;
                  end else begin
                     cmd.last = 1'b0;
                     wlen_in  = len_eff;
                  end
               end
            end
            KIND_CLEAR: begin
               wp_in        = '0;
               rp_in        = '0;
               wleft_in     = '0;
               wlen_in      = '0;
               wdrop_in     = 1'b0;
               cmd_push     = 1'b1;
               cmd.op       = CMD_CLEAR;
               cmd.held_cnt = '0;
               cmd.free_cnt = usable;
            end
            KIND_READ, KIND_PEEK: begin
               cmd_push = 1'b1;
               if (req_length == '0) begin
                  cmd.op = CMD_RESULT;
               end else if (bad_read) begin
                  cmd.status = 1'b1;
               end else begin
                  cmd.len = req_length;
                  if (req_kind == KIND_READ) begin
                     cmd.op       = CMD_READ;
                     cmd.held_cnt = held_cnt - CNT_W'(req_length);
                     cmd.free_cnt = free_cnt + CNT_W'(req_length);
                     rp_in = (rsum_x >= slots_x) ? PW'(rsum_x - slots_x) : PW'(rsum_x);
                  end else begin
                     cmd.op = CMD_PEEK;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CNT_W'(CNT_MAX);
         wp_ff    <= '0;
         rp_ff    <= '0;
         wleft_ff <= '0;
         wlen_ff  <= '0;
         wdrop_ff <= 1'b0;
      end else begin
         cap_ff   <= cap_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         wleft_ff <= wleft_in;
         wlen_ff  <= wlen_in;
         wdrop_ff <= wdrop_in;
      end
   end

endmodule

// ===== hdl/brf_cmdq.sv =====
// ----------------------------------------------------------------------------
// brf_cmdq
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module brf_cmdq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  brf_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output brf_pkg::cmd_type      pop_cmd,
   output brf_pkg::q_status_type q_status
);
   import brf_pkg::*;

   cmd_type              entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (CMDQ_AW+1)'(CMDQ_DEPTH));
   assign do_push        = push & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign pop_cmd        = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/brf_back.sv =====
// ----------------------------------------------------------------------------
// brf_back
// Back end: owns the ring memory, carries out queued commands one beat per
// cycle while its two-entry output queue has room, and buffers result beats there.
// ----------------------------------------------------------------------------
module brf_back #(
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      ring_clear,
   input  logic [brf_pkg::CNT_W-1:0] usable,
   input  brf_pkg::q_status_type     q_status,
   input  brf_pkg::cmd_type          q_cmd,
   output logic                      q_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output brf_pkg::rsp_type          rsp,
   output logic                      idle
);
   import brf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HW = ((PW > CNT_W) ? PW : CNT_W) + 1;

   typedef enum logic {ST_IDLE, ST_STREAM} state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [PW-1:0]     scan_ff, scan_in;
   logic [PW-1:0]     wp_ff, wp_in;
   logic [PW-1:0]     rp_ff, rp_in;
   cmd_type           cur_ff, cur_in;
   logic              s_vld_ff, s_vld_in;
   logic              s_mem_ff, s_mem_in;
   rsp_type           s_rsp_ff, s_rsp_in;
   rsp_type           ofifo_ff [2];
   logic              head_ff, head_in;
   logic [1:0]        cnt_ff, cnt_in;

   logic [BYTE_W-1:0] ring_ff [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic              mem_we;
   logic [PW-1:0]     scan_nx;

   logic              pop_hit, can_issue, last_beat;
   rsp_type           push_rsp;

   function automatic logic [PW-1:0] adv1(input logic [PW-1:0] p,
                                          input logic [CNT_W-1:0] u);
      return (HW'(p) >= HW'(u)) ? '0 : p + 1'b1;
   endfunction

   assign pop_hit   = rsp_pop & (cnt_ff != '0);
   assign can_issue = (3'(cnt_ff) + 3'(s_vld_ff)) <= (3'd1 + 3'(pop_hit));
   assign last_beat = (left_ff == LEN_W'(1));
   assign scan_nx   = adv1(scan_ff, usable);
   assign rsp_empty = (cnt_ff == '0);
   assign rsp       = ofifo_ff[head_ff];
   assign idle      = (state_ff == ST_IDLE) & ~s_vld_ff & (cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      scan_in  = scan_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      cur_in   = cur_ff;
      s_vld_in = 1'b0;
      s_mem_in = 1'b0;
      s_rsp_in = s_rsp_ff;
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      if (ring_clear) begin
         wp_in = '0;
         rp_in = '0;
      end else if (can_issue) begin
         unique case (state_ff)
            ST_STREAM: begin
               s_vld_in          = 1'b1;
               s_mem_in          = 1'b1;
               s_rsp_in.status   = 1'b0;
               s_rsp_in.data     = '0;
               s_rsp_in.last     = last_beat;
               s_rsp_in.moved    = last_beat ? cur_ff.len : '0;
               s_rsp_in.held_cnt = cur_ff.held_cnt;
               s_rsp_in.free_cnt = cur_ff.free_cnt;
               scan_in           = scan_nx;
               left_in           = left_ff - 1'b1;
               if (last_beat) begin
                  state_in = ST_IDLE;
                  if (cur_ff.op == CMD_READ) begin
                     rp_in = scan_nx;
                  end
               end
            end
            ST_IDLE: begin
               if (!q_status.empty) begin
                  q_pop             = 1'b1;
                  s_rsp_in.status   = q_cmd.status;
                  s_rsp_in.data     = '0;
                  s_rsp_in.last     = q_cmd.last;
                  s_rsp_in.moved    = q_cmd.len;
                  s_rsp_in.held_cnt = q_cmd.held_cnt;
                  s_rsp_in.free_cnt = q_cmd.free_cnt;
                  unique case (q_cmd.op)
                     CMD_WRITE: begin
                        mem_we   = 1'b1;
                        wp_in    = adv1(wp_ff, usable);
                        s_vld_in = 1'b1;
                     end
                     CMD_CLEAR: begin
                        wp_in    = '0;
                        rp_in    = '0;
                        s_vld_in = 1'b1;
                     end
                     CMD_READ, CMD_PEEK: begin
                        cur_in   = q_cmd;
                        left_in  = q_cmd.len;
                        scan_in  = rp_ff;
                        state_in = ST_STREAM;
                     end
                     default: begin
                        s_vld_in = 1'b1;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_comb begin
      push_rsp      = s_rsp_ff;
      push_rsp.data = s_mem_ff ? rdata_ff : '0;
   end

   assign head_in = head_ff ^ pop_hit;
   assign cnt_in  = cnt_ff + 2'(s_vld_ff) - 2'(pop_hit);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_ff[wp_ff] <= q_cmd.data;
      end
      rdata_ff <= ring_ff[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (s_vld_ff) begin
         ofifo_ff[head_ff ^ cnt_ff[0]] <= push_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
         scan_ff  <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         s_vld_ff <= 1'b0;
         head_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         scan_ff  <= scan_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         s_vld_ff <= s_vld_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
      end
      cur_ff   <= cur_in;
      s_mem_ff <= s_mem_in;
      s_rsp_ff <= s_rsp_in;
   end

endmodule

// ===== hdl/byte_ring_fifo_block_transfer.sv =====
// Path: a first result beat reaches the rsp_ ports through the command queue,
// the back end stage register and the output queue; a read or peek first
// enters the streaming state. Rate while the output queue has room: one write
// byte, clear or rejected request per cycle; a read or peek holds the back end
// until its last beat, one beat per cycle from the single ring memory read port.
// Reset: synchronous; pointers and queues empty, capacity 1023, ring kept.
// ----------------------------------------------------------------------------
// byte_ring_fifo_block_transfer
// Byte ring FIFO with block writes, reads and peeks. A front end classifies
// requests, a command queue decouples it from the back end that owns the
// ring memory and streams result beats.
// ----------------------------------------------------------------------------
module byte_ring_fifo_block_transfer #(
   parameter int DEPTH    = 1024,
   parameter int MAX_XFER = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [brf_pkg::KIND_W-1:0]     req_kind,
   input  logic                           req_first,
   input  logic [brf_pkg::LEN_W-1:0]      req_length,
   input  logic [brf_pkg::BYTE_W-1:0]     req_data_in,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_status,
   output logic [brf_pkg::BYTE_W-1:0]     rsp_data_out,
   output logic                           rsp_last,
   output logic [brf_pkg::LEN_W-1:0]      rsp_moved,
   output logic [brf_pkg::CNT_W-1:0]      rsp_held_count,
   output logic [brf_pkg::CNT_W-1:0]      rsp_free_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [brf_pkg::CNT_W-1:0]      csr_data
);
   import brf_pkg::*;

   q_status_type     q_status;
   cmd_type          push_cmd, pop_cmd;
   logic             cmd_push, q_pop, back_idle, csr_wr;
   logic [CNT_W-1:0] usable;
   rsp_type          rsp;

   assign csr_ready = q_status.empty & back_idle & ~req_push;
   assign csr_wr    = csr_valid & csr_ready;
   assign req_full  = q_status.full;

   brf_front #(
      .DEPTH    (DEPTH),
      .MAX_XFER (MAX_XFER)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_kind    (req_kind),
      .req_first   (req_first),
      .req_length  (req_length),
      .req_data_in (req_data_in),
      .csr_wr      (csr_wr),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .usable      (usable)
   );

   brf_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   brf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ring_clear (csr_wr),
      .usable     (usable),
      .q_status   (q_status),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp),
      .idle       (back_idle)
   );

   assign rsp_status     = rsp.status;
   assign rsp_data_out   = rsp.data;
   assign rsp_last       = rsp.last;
   assign rsp_moved      = rsp.moved;
   assign rsp_held_count = rsp.held_cnt;
   assign rsp_free_count = rsp.free_cnt;

   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status) |-> rsp_last)
      else $error("rejected beat without last");

   a_moved_on_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_moved != '0) |-> (rsp_last && !rsp_status))
      else $error("moved count on a non-final or rejected beat");

   a_counts_fit: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((11'(rsp_held_count) + 11'(rsp_free_count)) <= 11'(CNT_MAX)))
      else $error("held plus free exceeds capacity");

   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_status.full)
      else $error("command pushed into a full queue");

endmodule

// ===== tb/byte_ring_fifo_block_transfer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_block_transfer_test
// Drives block writes, reads, peeks and clears into the byte ring FIFO under
// several capacities, with random gaps and stalls on both queue sides. A
// software copy of the ring predicts every result beat, and each popped beat
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module byte_ring_fifo_block_transfer_test;

   import brf_pkg::*;

   localparam int RING_SLOTS = 1024;
   localparam int XFER_MAX   = 64;

   class ring_mirror;
      logic [BYTE_W-1:0] ring [RING_SLOTS];
      int unsigned       wr_ptr;
      int unsigned       rd_ptr;
      int unsigned       wr_left;
      int unsigned       wr_len;
      bit                wr_drop;
      int unsigned       capacity;
      rsp_type           beats_due [$];
      int                errors;

      function new();
         capacity = CNT_MAX;
         errors   = 0;
         empty_ring();
      endfunction

      function void empty_ring();
         wr_ptr  = 0;
         rd_ptr  = 0;
         wr_left = 0;
         wr_len  = 0;
         wr_drop = 1'b0;
      endfunction

      function void load_capacity(int unsigned c);
         capacity = (c > RING_SLOTS - 1) ? RING_SLOTS - 1 : c;
         empty_ring();
      endfunction

      function int unsigned held_bytes();
         return (wr_ptr + capacity + 1 - rd_ptr) % (capacity + 1);
      endfunction

      function int unsigned step_ptr(int unsigned p);
         return (p + 1 >= capacity + 1) ? 0 : p + 1;
      endfunction

      function int pending();
         return beats_due.size();
      endfunction

      function void post(bit status, logic [BYTE_W-1:0] data, bit last, int unsigned moved);
         rsp_type     beat;
         int unsigned h;
         h              = held_bytes();
         beat.status    = status;
         beat.data      = data;
         beat.last      = last;
         beat.moved     = moved[LEN_W-1:0];
         beat.held_cnt  = h[CNT_W-1:0];
         beat.free_cnt  = CNT_W'(capacity - h);
         beats_due.push_back(beat);
      endfunction

      // returns the number of result beats the request causes
      function int note_request(logic [KIND_W-1:0] kind, logic first,
                                logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data);
         logic [BYTE_W-1:0] bytes [XFER_MAX];
         int unsigned       p;
         if (kind == KIND_WRITE) begin
            if (first) begin
               if (len == 0 || len > XFER_MAX || len > capacity - held_bytes()) begin
                  wr_drop = 1'b1;
                  wr_left = 0;
                  wr_len  = 0;
                  post(1'b1, 8'd0, 1'b1, 0);
                  return 1;
               end
               wr_drop = 1'b0;
               wr_len  = 32'(len);
               wr_left = 32'(len);
            end else if (wr_drop || wr_left == 0) begin
               return 0;
            end
            ring[wr_ptr] = data;
            wr_ptr       = step_ptr(wr_ptr);
            wr_left--;
            if (wr_left == 0) begin
               post(1'b0, 8'd0, 1'b1, wr_len);
               wr_len = 0;
            end else begin
               post(1'b0, 8'd0, 1'b0, 0);
            end
            return 1;
         end
         if (kind == KIND_CLEAR) begin
            empty_ring();
            post(1'b0, 8'd0, 1'b1, 0);
            return 1;
         end
         if (len == 0) begin
            post(1'b0, 8'd0, 1'b1, 0);
            return 1;
         end
         if (len > XFER_MAX || len > held_bytes()) begin
            post(1'b1, 8'd0, 1'b1, 0);
            return 1;
         end
         p = rd_ptr;
         for (int i = 0; i < len; i++) begin
            bytes[i] = ring[p];
            p        = step_ptr(p);
         end
         if (kind == KIND_READ) rd_ptr = p;
         for (int i = 0; i < len; i++) begin
            post(1'b0, bytes[i], i + 1 == len, (i + 1 == len) ? 32'(len) : 0);
         end
         return int'(len);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(rsp_type got);
         rsp_type want;
         if (beats_due.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = beats_due.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("data_out", want.data, got.data);
         compare_field("last", want.last, got.last);
         compare_field("moved", want.moved, got.moved);
         compare_field("held_count", want.held_cnt, got.held_cnt);
         compare_field("free_count", want.free_cnt, got.free_cnt);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [KIND_W-1:0]   req_kind;
   logic                req_first;
   logic [LEN_W-1:0]    req_length;
   logic [BYTE_W-1:0]   req_data_in;
   logic                rsp_empty;
   logic                rsp_pop;
   logic                rsp_status;
   logic [BYTE_W-1:0]   rsp_data_out;
   logic                rsp_last;
   logic [LEN_W-1:0]    rsp_moved;
   logic [CNT_W-1:0]    rsp_held_count;
   logic [CNT_W-1:0]    rsp_free_count;
   logic                csr_valid;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_data;

   ring_mirror mirror = new();

   bit feed_steady;
   bit drain_steady;
   bit squeeze_now;
   int sent;

   byte_ring_fifo_block_transfer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_first      (req_first),
      .req_length     (req_length),
      .req_data_in    (req_data_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_last       (rsp_last),
      .rsp_moved      (rsp_moved),
      .rsp_held_count (rsp_held_count),
      .rsp_free_count (rsp_free_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   initial begin : result_drain
      int      stall;
      rsp_type got;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.status   = rsp_status;
            got.data     = rsp_data_out;
            got.last     = rsp_last;
            got.moved    = rsp_moved;
            got.held_cnt = rsp_held_count;
            got.free_cnt = rsp_free_count;
            mirror.check_beat(got);
         end
         @(negedge clock);
         if (squeeze_now) begin
            // hold off long enough for the block to back up into req_full
            squeeze_now = 1'b0;
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            if (!drain_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   task automatic send_item(logic [KIND_W-1:0] kind, logic first,
                            logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data);
      int gap;
      gap = 0;
      if (!feed_steady && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push    <= 1'b1;
      req_kind    <= kind;
      req_first   <= first;
      req_length  <= len;
      req_data_in <= data;
      @(posedge clock);
      while (req_full) @(posedge clock);
      void'(mirror.note_request(kind, first, len, data));
      sent++;
   endtask

   task automatic send_write(int unsigned len, int unsigned beats);
      for (int i = 0; i < beats; i++) begin
         send_item(KIND_WRITE, i == 0, (i == 0) ? len[LEN_W-1:0] : LEN_W'($urandom),
                   BYTE_W'($urandom));
      end
   endtask

   task automatic send_fetch(int unsigned len);
      logic [KIND_W-1:0] kind;
      kind = $urandom_range(0, 1) ? KIND_READ : KIND_PEEK;
      send_item(kind, 1'($urandom), len[LEN_W-1:0], BYTE_W'($urandom));
   endtask

   task automatic random_request();
      int unsigned h;
      int unsigned room;
      int unsigned len;
      int unsigned lim;
      int          pick;
      h    = mirror.held_bytes();
      room = mirror.capacity - h;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if (room == 0 || $urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, XFER_MAX);
            send_write(len, (len < 4) ? len : 4);
         end else begin
            lim = (room < XFER_MAX) ? room : XFER_MAX;
            if (lim > 8 && $urandom_range(0, 7) != 0) lim = 8;
            len = $urandom_range(1, lim);
            send_write(len, len);
         end
      end else if (pick < 75) begin
         if (h == 0) len = $urandom_range(0, 1);
         else if ($urandom_range(0, 4) == 0) len = (h < XFER_MAX) ? h : XFER_MAX;
         else len = $urandom_range(1, (h < XFER_MAX) ? h : XFER_MAX);
         send_fetch(len);
      end else if (pick < 80) begin
         send_item(KIND_CLEAR, 1'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
      end else begin
         case ($urandom_range(0, 3))
            0: send_fetch($urandom_range(0, 127));
            1: send_write($urandom_range(XFER_MAX + 1, 127), $urandom_range(1, 4));
            2: send_item(KIND_WRITE, 1'b0, LEN_W'($urandom), BYTE_W'($urandom));
            default: begin
               len = $urandom_range(2, 8);
               send_write(len, $urandom_range(1, len - 1));
            end
         endcase
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_capacity(int unsigned c);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= c[CNT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mirror.load_capacity(c);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_items();
      send_item(KIND_READ, 1'b0, 7'd0, 8'h00);
      send_item(KIND_READ, 1'b1, 7'd1, 8'hFF);
      send_item(KIND_PEEK, 1'b0, 7'd127, 8'h00);
      send_item(KIND_WRITE, 1'b0, 7'd3, 8'h11);
      send_item(KIND_WRITE, 1'b1, 7'd0, 8'h22);
      send_item(KIND_WRITE, 1'b0, 7'd1, 8'h33);
      send_item(KIND_WRITE, 1'b1, 7'd65, 8'h44);
      send_item(KIND_WRITE, 1'b0, 7'd0, 8'h55);
      send_item(KIND_WRITE, 1'b1, 7'd3, 8'hFF);
      send_item(KIND_WRITE, 1'b0, 7'd127, 8'h00);
      send_item(KIND_WRITE, 1'b0, 7'd0, 8'h5A);
      // abandon a transfer by opening a new one
      send_item(KIND_WRITE, 1'b1, 7'd2, 8'h01);
      send_item(KIND_WRITE, 1'b1, 7'd1, 8'h02);
      send_item(KIND_PEEK, 1'b1, 7'd5, 8'hFF);
      send_item(KIND_READ, 1'b0, 7'd2, 8'h00);
      send_item(KIND_READ, 1'b0, 7'd64, 8'h00);
      send_item(KIND_PEEK, 1'b0, 7'd3, 8'h00);
      send_item(KIND_CLEAR, 1'b1, 7'd127, 8'hFF);
      send_item(KIND_READ, 1'b0, 7'd1, 8'h00);
   endtask

   initial begin : stimulus
      int unsigned caps [5];
      int          quota [5];
      reset        = 1'b1;
      req_push     = 1'b0;
      req_kind     = KIND_WRITE;
      req_first    = 1'b0;
      req_length   = '0;
      req_data_in  = '0;
      rsp_pop      = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      feed_steady  = 1'b0;
      drain_steady = 1'b0;
      squeeze_now  = 1'b0;
      sent         = 0;
      caps  = '{CNT_MAX, 1, 3, 100, $urandom_range(2, CNT_MAX)};
      quota = '{50, 40, 40, 45, 45};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         write_capacity(caps[ph]);
         feed_steady  = (ph == 0 || ph == 3);
         drain_steady = (ph == 1);
         sent = 0;
         if (ph == 0) directed_items();
         if (ph == 0) squeeze_now = 1'b1;
         while (sent < quota[ph]) random_request();
         settle();
      end
      repeat (20) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
